FILE: rtl/atrt_pkg.sv
// shared types and constants of the at reply tracker
`default_nettype none

package atrt_pkg;

  // input item codes
  localparam logic [1:0] MODE_RX    = 2'd0;
  localparam logic [1:0] MODE_CMD   = 2'd1;
  localparam logic [1:0] MODE_BEGIN = 2'd2;

  // line event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_OK    = 2'd1;
  localparam logic [1:0] EV_ERR   = 2'd2;
  localparam logic [1:0] EV_OTHER = 2'd3;

  // characters
  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] CHAR_LF  = 8'h0a;
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_O   = 8'h4f;
  localparam logic [7:0] CHAR_K   = 8'h4b;
  localparam logic [7:0] CHAR_E   = 8'h45;
  localparam logic [7:0] CHAR_R   = 8'h52;

  // first bytes of a line kept for matching
  localparam int unsigned HeadDepth = 5;
  localparam int unsigned HeadIdxW  = 3;
  localparam int unsigned OkLen     = 2;

  localparam int unsigned CntW = 4;

  // classified work handed from front to back
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_OK    = 3'd1,
    OP_ERR   = 3'd2,
    OP_OTHER = 3'd3,
    OP_CMD   = 3'd4,
    OP_BEGIN = 3'd5
  } op_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic            accepted;
    logic [1:0]      line_event;
    logic [15:0]     ok_total;
    logic [15:0]     error_total;
    logic [CntW-1:0] pending_total;
    logic [CntW-1:0] commands_total;
    logic [CntW-1:0] reply_position;
    logic            failure_seen;
    logic [CntW-1:0] failed_command;
    logic            transaction_ok;
  } out_t;

  // handshake between front, queue and back
  typedef struct packed {
    logic valid;
    op_e  op;
  } op_req_t;

endpackage

`default_nettype wire

FILE: rtl/at_response_tracker_core.sv
// top level of the at reply tracker: front, queue and back
//
//  channel | direction | handshake                  | payload
//  in      | input     | in_valid_i / in_ready_o    | in_data_i  (in_t)
//  out     | output    | out_valid_o / out_ready_i  | out_data_o (out_t)
//
// one item per cycle while the output does not stall; an accepted item is
// written into the queue, then moved into the result register, where its
// result appears.
// the front updates the line state in the accept cycle; the back updates
// the counters as it moves an item from the queue into the result register.
// reset clears line and counter state; no clearing pass is needed.
// a stalled output fills the two-entry queue, after which in_ready_o drops.
`default_nettype none

module at_response_tracker_core import atrt_pkg::*; #(
  parameter int unsigned MAX_COMMANDS  = 12,
  parameter int unsigned LINE_CAPACITY = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  op_req_t front_req;
  logic    front_ready;
  op_req_t back_req;
  logic    back_ready;

  atrt_front #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_ready_o (in_ready_o),
    .req_o      (front_req),
    .req_ready_i(front_ready)
  );

  atrt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_req),
    .push_ready_o(front_ready),
    .pop_o       (back_req),
    .pop_ready_i (back_ready)
  );

  atrt_back #(
    .MAX_COMMANDS(MAX_COMMANDS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (back_req),
    .req_ready_o(back_ready),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_ready_i(out_ready_i)
  );

endmodule

`default_nettype wire

FILE: rtl/atrt_front.sv
// front: line assembly and classification of each input item
`default_nettype none

module atrt_front import atrt_pkg::*; #(
  parameter int unsigned LINE_CAPACITY = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire in_t  in_data_i,
  output logic      in_ready_o,
  output op_req_t   req_o,
  input  wire logic req_ready_i
);

  localparam int unsigned LenW = $clog2(LINE_CAPACITY);
  localparam logic [LenW-1:0] LastLen = LenW'(LINE_CAPACITY - 1);

  logic [LenW-1:0] len_q, len_d;
  logic            cr_q, cr_d;
  logic            nul_seen_q, nul_seen_d;
  logic [LenW-1:0] nul_pos_q, nul_pos_d;
  logic [7:0]      head_q [HeadDepth];

  logic            accept;
  logic            is_lf;
  logic            head_wr;
  logic [LenW-1:0] len_eff;
  logic [LenW-1:0] text_len;
  logic            is_ok;
  logic            is_err;
  op_e             op;

  assign accept     = in_valid_i && req_ready_i;
  assign in_ready_o = req_ready_i;
  assign is_lf      = (in_data_i.rx_byte == CHAR_LF);

  always_comb begin
    len_eff = len_q;
    if (cr_q && (len_q != '0)) begin
      len_eff = len_q - LenW'(1);
    end
    text_len = (nul_seen_q && (nul_pos_q < len_eff)) ? nul_pos_q : len_eff;
    is_ok  = (text_len == LenW'(OkLen)) && (head_q[0] == CHAR_O) && (head_q[1] == CHAR_K);
    is_err = (text_len >= LenW'(HeadDepth)) && (head_q[0] == CHAR_E)
             && (head_q[1] == CHAR_R) && (head_q[2] == CHAR_R)
             && (head_q[3] == CHAR_O) && (head_q[4] == CHAR_R);
  end

  always_comb begin
    len_d      = len_q;
    cr_d       = cr_q;
    nul_seen_d = nul_seen_q;
    nul_pos_d  = nul_pos_q;
    head_wr    = 1'b0;
    op         = OP_NONE;
    case (in_data_i.mode)
      MODE_RX: begin
        if (is_lf) begin
          if (len_eff == '0) begin
            op = OP_NONE;
          end else if (is_ok) begin
            op = OP_OK;
          end else if (is_err) begin
            op = OP_ERR;
          end else begin
            op = OP_OTHER;
          end
          len_d      = '0;
          cr_d       = 1'b0;
          nul_seen_d = 1'b0;
        end else if (len_q < LastLen) begin
          head_wr = (len_q < LenW'(HeadDepth));
          if ((in_data_i.rx_byte == CHAR_NUL) && !nul_seen_q) begin
            nul_seen_d = 1'b1;
            nul_pos_d  = len_q;
          end
          cr_d  = (in_data_i.rx_byte == CHAR_CR);
          len_d = len_q + LenW'(1);
        end else begin
          // line too long: drop the byte and discard the line
          op         = OP_OTHER;
          len_d      = '0;
          cr_d       = 1'b0;
          nul_seen_d = 1'b0;
        end
      end
      MODE_CMD:   op = OP_CMD;
      MODE_BEGIN: op = OP_BEGIN;
      default:    op = OP_NONE;
    endcase
  end

  assign req_o.valid = in_valid_i;
  assign req_o.op    = op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      cr_q       <= 1'b0;
      nul_seen_q <= 1'b0;
    end else if (accept) begin
      len_q      <= len_d;
      cr_q       <= cr_d;
      nul_seen_q <= nul_seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      nul_pos_q <= nul_pos_d;
      if (head_wr) begin
        head_q[len_q[HeadIdxW-1:0]] <= in_data_i.rx_byte;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/atrt_queue.sv
// two-entry queue of classified items between front and back
`default_nettype none

module atrt_queue import atrt_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire op_req_t push_i,
  output logic         push_ready_o,
  output op_req_t      pop_o,
  input  wire logic    pop_ready_i
);

  op_e        mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push;
  logic       do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_o.valid  = (cnt_q != 2'd0);
  assign pop_o.op     = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && push_ready_o;
  assign do_pop       = pop_o.valid && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.op;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/atrt_back.sv
// back: reply counters, command bookkeeping and the result register
`default_nettype none

module atrt_back import atrt_pkg::*; #(
  parameter int unsigned MAX_COMMANDS = 12
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire op_req_t req_i,
  output logic         req_ready_o,
  output logic         out_valid_o,
  output out_t         out_data_o,
  input  wire logic    out_ready_i
);

  localparam logic [CntW-1:0] MaxCmd = CntW'(MAX_COMMANDS);

  logic [15:0]     ok_q, ok_d;
  logic [15:0]     err_q, err_d;
  logic [CntW-1:0] pend_q, pend_d;
  logic [CntW-1:0] cmd_q, cmd_d;
  logic [CntW-1:0] reply_q, reply_d;
  logic [CntW-1:0] fail_idx_q, fail_idx_d;
  logic            fail_vld_q, fail_vld_d;
  logic            out_valid_q;
  out_t            out_q, out_d;
  logic            take;
  logic            accepted;
  logic [1:0]      ev;
  logic            matched;

  assign req_ready_o = !out_valid_q || out_ready_i;
  assign take        = req_i.valid && req_ready_o;
  assign matched     = (reply_q < cmd_q);

  always_comb begin
    ok_d       = ok_q;
    err_d      = err_q;
    pend_d     = pend_q;
    cmd_d      = cmd_q;
    reply_d    = reply_q;
    fail_idx_d = fail_idx_q;
    fail_vld_d = fail_vld_q;
    accepted   = 1'b1;
    ev         = EV_NONE;
    case (req_i.op)
      OP_OK, OP_ERR: begin
        if (req_i.op == OP_OK) begin
          ev   = EV_OK;
          ok_d = ok_q + 16'd1;
        end else begin
          ev    = EV_ERR;
          err_d = err_q + 16'd1;
          if (matched) begin
            fail_idx_d = reply_q;
            fail_vld_d = 1'b1;
          end
        end
        if (pend_q != '0) begin
          pend_d = pend_q - CntW'(1);
        end
        if (matched) begin
          reply_d = reply_q + CntW'(1);
        end
      end
      OP_OTHER: ev = EV_OTHER;
      OP_CMD: begin
        if (cmd_q >= MaxCmd) begin
          accepted = 1'b0;
        end else begin
          cmd_d  = cmd_q + CntW'(1);
          pend_d = pend_q + CntW'(1);
        end
      end
      OP_BEGIN: begin
        ok_d       = '0;
        err_d      = '0;
        pend_d     = '0;
        cmd_d      = '0;
        reply_d    = '0;
        fail_idx_d = '0;
        fail_vld_d = 1'b0;
      end
      default: ev = EV_NONE;
    endcase

    out_d.accepted       = accepted;
    out_d.line_event     = ev;
    out_d.ok_total       = ok_d;
    out_d.error_total    = err_d;
    out_d.pending_total  = pend_d;
    out_d.commands_total = cmd_d;
    out_d.reply_position = reply_d;
    out_d.failure_seen   = fail_vld_d;
    out_d.failed_command = fail_idx_d;
    out_d.transaction_ok = (ok_d != '0) && (pend_d == '0) && (err_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q        <= '0;
      err_q       <= '0;
      pend_q      <= '0;
      cmd_q       <= '0;
      reply_q     <= '0;
      fail_idx_q  <= '0;
      fail_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        ok_q       <= ok_d;
        err_q      <= err_d;
        pend_q     <= pend_d;
        cmd_q      <= cmd_d;
        reply_q    <= reply_d;
        fail_idx_q <= fail_idx_d;
        fail_vld_q <= fail_vld_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/atrt_checker.sv
// port-level assertions for the at reply tracker and their bind
`default_nettype none

module atrt_checker import atrt_pkg::*; #(
  parameter int unsigned MAX_COMMANDS = 12
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_data_o
);

  localparam logic [CntW-1:0] MaxCmd = CntW'(MAX_COMMANDS);

  // a result waiting on the output holds still
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // a refused command only happens with the command list full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.accepted |-> out_data_o.commands_total == MaxCmd)
    else $error("command refused below capacity");

  // pending and reply index never pass the recorded commands
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pending_total <= out_data_o.commands_total)
                 && (out_data_o.reply_position <= out_data_o.commands_total))
    else $error("pending or reply index beyond recorded commands");

  // no failure latched means the failed index is still clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.failure_seen |-> out_data_o.failed_command == '0)
    else $error("failed index set without a failure");

  // overall status follows the reported totals
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.transaction_ok ==
      ((out_data_o.ok_total != '0) && (out_data_o.pending_total == '0)
       && (out_data_o.error_total == '0)))
    else $error("transaction status disagrees with totals");

endmodule

bind at_response_tracker_core atrt_checker #(
  .MAX_COMMANDS(MAX_COMMANDS)
) u_atrt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire
